[rtl/core/nt_pkg.sv]
`timescale 1ns / 1ps

package nt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = 7;
    localparam int ADDR_W = 32;
    localparam int TIME_W = 32;
    localparam int ENTRY_W = 2 * ADDR_W + TIME_W;

    localparam logic [ADDR_W-1:0] RESERVED_LINK = 32'd666;
    localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = 32'd10240;

    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_AGE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_LEARN   = 2'd0,
        KIND_REFRESH = 2'd1,
        KIND_LOOKUP  = 2'd2,
        KIND_SWEEP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_stat_t;

endpackage

[rtl/core/nt_ram.sv]
`timescale 1ns / 1ps

module nt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/nt_ctrl.sv]
`timescale 1ns / 1ps

module nt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  nt_pkg::dp_stat_t   stat,
    output nt_pkg::ctrl_cmd_t  cmd,
    output logic               busy
);

    nt_pkg::state_t state_reg;
    nt_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = nt_pkg::S_SCAN;
                end
            end
            nt_pkg::S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = nt_pkg::S_COMMIT;
                end
            end
            nt_pkg::S_COMMIT:
            begin
                state_next = nt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = nt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            nt_pkg::S_IDLE:
            begin
                busy = 1'b0;
                cmd.load = start;
            end
            nt_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            nt_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/nt_datapath.sv]
`timescale 1ns / 1ps

module nt_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nt_pkg::ctrl_cmd_t               cmd,
    output nt_pkg::dp_stat_t                stat,
    input  logic [1:0]                      kind,
    input  logic [nt_pkg::ADDR_W-1:0]       link_address,
    input  logic [nt_pkg::ADDR_W-1:0]       net_address,
    input  logic                            add_if_absent,
    input  logic [nt_pkg::TIME_W-1:0]       now_ticks,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic                            done,
    output logic [2:0]                      status,
    output logic                            found,
    output logic [nt_pkg::ADDR_W-1:0]       found_net_address,
    output logic [nt_pkg::CNT_W-1:0]        removed_count,
    output logic [nt_pkg::CNT_W-1:0]        entry_count
);

    localparam int N = nt_pkg::TABLE_ENTRIES;
    localparam int IW = nt_pkg::IDX_W;
    localparam int CW = nt_pkg::CNT_W;
    localparam int AW = nt_pkg::ADDR_W;
    localparam int TW = nt_pkg::TIME_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    // request
    nt_pkg::kind_t kind_reg, kind_next;
    logic [AW-1:0] key_reg, key_next;
    logic [AW-1:0] ip_reg, ip_next;
    logic          add_reg, add_next;
    logic [TW-1:0] now_reg, now_next;

    // configuration
    logic [AW-1:0] own_reg, own_next;
    logic [TW-1:0] limit_reg, limit_next;

    // table control
    logic [N-1:0]  valid_reg, valid_next;
    logic [CW-1:0] count_reg, count_next;

    // scan
    logic [IW:0]   issue_reg, issue_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          match_reg, match_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    logic [AW-1:0] match_net_reg, match_net_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [CW-1:0] removed_reg, removed_next;

    // result
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic          found_reg, found_next;
    logic [AW-1:0] found_ip_reg, found_ip_next;
    logic [CW-1:0] removed_out_reg, removed_out_next;
    logic [CW-1:0] entry_count_reg, entry_count_next;

    // memory
    logic                         rd_en;
    logic [nt_pkg::ENTRY_W-1:0]   rd_data;
    logic [AW-1:0]                rd_link;
    logic [AW-1:0]                rd_net;
    logic [TW-1:0]                rd_seen;
    logic                         wr_en;
    logic [IW-1:0]                wr_idx;
    logic [nt_pkg::ENTRY_W-1:0]   wr_data;

    logic          ent_valid;
    logic          hit;
    logic          stale;
    logic          empty_slot;
    logic [TW-1:0] age;
    logic          rejected;
    logic          insert;

    assign rd_en = cmd.scan && !issue_reg[IW];
    assign {rd_link, rd_net, rd_seen} = rd_data;

    assign ent_valid  = valid_reg[cmp_idx_reg];
    assign age        = now_reg - rd_seen;
    assign hit        = cmp_valid_reg && ent_valid && (rd_link == key_reg);
    assign stale      = cmp_valid_reg && ent_valid && (age > limit_reg)
                        && (kind_reg == nt_pkg::KIND_SWEEP);
    assign empty_slot = cmp_valid_reg && !ent_valid;

    assign stat.scan_last = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);

    assign rejected = (key_reg == own_reg) || (key_reg == '0)
                      || (key_reg == nt_pkg::RESERVED_LINK) || (ip_reg == '0);

    nt_ram #(
        .WIDTH (nt_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_entry_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (issue_reg[IW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        kind_next = kind_reg;
        key_next = key_reg;
        ip_next = ip_reg;
        add_next = add_reg;
        now_next = now_reg;
        own_next = own_reg;
        limit_next = limit_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        issue_next = issue_reg;
        cmp_valid_next = rd_en;
        cmp_idx_next = issue_reg[IW-1:0];
        match_next = match_reg;
        match_idx_next = match_idx_reg;
        match_net_next = match_net_reg;
        free_next = free_reg;
        free_idx_next = free_idx_reg;
        removed_next = removed_reg;
        done_next = 1'b0;
        status_next = status_reg;
        found_next = found_reg;
        found_ip_next = found_ip_reg;
        removed_out_next = removed_out_reg;
        entry_count_next = entry_count_reg;
        wr_en = 1'b0;
        wr_idx = match_idx_reg;
        wr_data = {key_reg, ip_reg, now_reg};
        insert = 1'b0;

        if (cfg_write)
        begin
            if (cfg_index == nt_pkg::CFG_OWN_ADDRESS)
            begin
                own_next = cfg_data;
            end
            else
            begin
                limit_next = cfg_data;
            end
        end

        if (cmd.load)
        begin
            kind_next = nt_pkg::kind_t'(kind);
            key_next = link_address;
            ip_next = net_address;
            add_next = add_if_absent;
            now_next = now_ticks;
            issue_next = '0;
            match_next = 1'b0;
            free_next = 1'b0;
            removed_next = '0;
        end

        if (rd_en)
        begin
            issue_next = issue_reg + 1'b1;
        end

        // keep the first hit and the lowest free slot
        if (hit && !match_reg)
        begin
            match_next = 1'b1;
            match_idx_next = cmp_idx_reg;
            match_net_next = rd_net;
        end
        if (empty_slot && !free_reg)
        begin
            free_next = 1'b1;
            free_idx_next = cmp_idx_reg;
        end
        if (stale)
        begin
            valid_next[cmp_idx_reg] = 1'b0;
            removed_next = removed_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end

        if (cmd.commit)
        begin
            done_next = 1'b1;
            found_next = 1'b0;
            found_ip_next = '0;
            removed_out_next = '0;
            status_next = nt_pkg::ST_NOT_FOUND;
            case (kind_reg)
                nt_pkg::KIND_LEARN:
                begin
                    if (rejected)
                    begin
                        status_next = nt_pkg::ST_IGNORED;
                    end
                    else if (match_reg)
                    begin
                        status_next = nt_pkg::ST_UPDATED;
                        found_next = 1'b1;
                        found_ip_next = ip_reg;
                        wr_en = 1'b1;
                    end
                    else if (add_reg)
                    begin
                        if (free_reg)
                        begin
                            status_next = nt_pkg::ST_INSERTED;
                            insert = 1'b1;
                            wr_en = 1'b1;
                            wr_idx = free_idx_reg;
                        end
                        else
                        begin
                            status_next = nt_pkg::ST_FULL;
                        end
                    end
                end
                nt_pkg::KIND_REFRESH, nt_pkg::KIND_LOOKUP:
                begin
                    if (match_reg)
                    begin
                        status_next = nt_pkg::ST_UPDATED;
                        found_next = 1'b1;
                        found_ip_next = match_net_reg;
                        wr_en = (kind_reg == nt_pkg::KIND_REFRESH);
                        wr_data = {key_reg, match_net_reg, now_reg};
                    end
                end
                nt_pkg::KIND_SWEEP:
                begin
                    status_next = nt_pkg::ST_UPDATED;
                    removed_out_next = removed_reg;
                end
                default:
                begin
                    status_next = nt_pkg::ST_NOT_FOUND;
                end
            endcase
            if (insert)
            begin
                valid_next[free_idx_reg] = 1'b1;
                count_next = count_reg + 1'b1;
            end
            entry_count_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg <= '0;
            limit_reg <= nt_pkg::AGE_LIMIT_RESET;
            valid_reg <= '0;
            count_reg <= '0;
            issue_reg <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg <= 1'b0;
            free_reg <= 1'b0;
            removed_reg <= '0;
            done_reg <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            own_reg <= own_next;
            limit_reg <= limit_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            match_reg <= match_next;
            free_reg <= free_next;
            removed_reg <= removed_next;
            done_reg <= done_next;
            entry_count_reg <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        key_reg <= key_next;
        ip_reg <= ip_next;
        add_reg <= add_next;
        now_reg <= now_next;
        cmp_idx_reg <= cmp_idx_next;
        match_idx_reg <= match_idx_next;
        match_net_reg <= match_net_next;
        free_idx_reg <= free_idx_next;
        status_reg <= status_next;
        found_reg <= found_next;
        found_ip_reg <= found_ip_next;
        removed_out_reg <= removed_out_next;
    end

    assign done = done_reg;
    assign status = status_reg;
    assign found = found_reg;
    assign found_net_address = found_ip_reg;
    assign removed_count = removed_out_reg;
    assign entry_count = entry_count_reg;

endmodule

[rtl/core/neighbour_table_with_aging.sv]
`timescale 1ns / 1ps

// neighbour table keyed by link address, holding an ip address and last-seen time
// request channel: a request is taken at a clock edge where start is high and busy is low;
//   kind selects learn, refresh, lookup or age sweep
// every request walks the whole table once through the single read port of the entry ram:
//   one read issued per cycle, compare in the cycle after its read, then a commit state
// done is registered from the commit state, and the result is taken at the edge that
//   ends the cycle in which done is high; busy is low in that same cycle, so a new
//   request can be taken at that edge, but not while a request is still in flight
// result ports (status, found, found_net_address, removed_count, entry_count) are valid
//   while done is high; the receiver cannot stall them, they hold until the next result
// config channel: cfg_valid/cfg_ready with cfg_index (0 own address, 1 age limit) and
//   cfg_data; cfg_ready is always high, write only while no request is in flight
// reset clears all entry valid bits, the entry count, own address (0) and sets the age
//   limit to 10240 ticks; no clearing pass is needed, the block is ready right after reset
module neighbour_table_with_aging (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] link_address,
    input  logic [31:0] net_address,
    input  logic        add_if_absent,
    input  logic [31:0] now_ticks,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic        found,
    output logic [31:0] found_net_address,
    output logic [6:0]  removed_count,
    output logic [6:0]  entry_count
);

    nt_pkg::ctrl_cmd_t cmd;
    nt_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    nt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    nt_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .kind              (kind),
        .link_address      (link_address),
        .net_address       (net_address),
        .add_if_absent     (add_if_absent),
        .now_ticks         (now_ticks),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .status            (status),
        .found             (found),
        .found_net_address (found_net_address),
        .removed_count     (removed_count),
        .entry_count       (entry_count)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= 7'(nt_pkg::TABLE_ENTRIES))
        else $error("entry count above table size");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == nt_pkg::ST_INSERTED)
        |-> entry_count == 7'($past(entry_count) + 7'd1))
        else $error("insert did not add one entry");

endmodule

[verif/neighbour_table_checker.sv]
`timescale 1ns / 1ps

module neighbour_table_checker
    import nt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] link_address,
    input  logic [31:0] net_address,
    input  logic        add_if_absent,
    input  logic [31:0] now_ticks,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic        found,
    input  logic [31:0] found_net_address,
    input  logic [6:0]  removed_count,
    input  logic [6:0]  entry_count,
    output int          mismatch_count,
    output int          replies_pending
);

    typedef struct packed {
        status_t     code;
        logic        hit;
        logic [31:0] ip;
        logic [6:0]  removed;
        logic [6:0]  count;
    } table_reply_t;

    logic              slot_used [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_key  [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_ip   [TABLE_ENTRIES];
    logic [TIME_W-1:0] slot_seen [TABLE_ENTRIES];
    logic [6:0]        live_count;
    logic [ADDR_W-1:0] own_addr_q;
    logic [TIME_W-1:0] age_limit_q;

    table_reply_t expected_replies [$];
    table_reply_t next_reply;
    table_reply_t oldest;
    int           errs;
    int           n;

    function automatic int slot_of(input logic [ADDR_W-1:0] key);
        int hit_slot;
        hit_slot = -1;
        for (int i = 0; i < TABLE_ENTRIES && hit_slot < 0; i++)
        begin
            if (slot_used[i] && slot_key[i] == key)
                hit_slot = i;
        end
        return hit_slot;
    endfunction

    task automatic predict_table_op(
        input  kind_t             op,
        input  logic [ADDR_W-1:0] key,
        input  logic [ADDR_W-1:0] ip,
        input  logic              add,
        input  logic [TIME_W-1:0] now,
        output table_reply_t      r
    );
        int          slot;
        logic [31:0] age;
        r.code    = ST_NOT_FOUND;
        r.hit     = 1'b0;
        r.ip      = '0;
        r.removed = '0;
        case (op)
            KIND_LEARN:
            begin
                if (key == own_addr_q || key == '0 || key == RESERVED_LINK || ip == '0)
                    r.code = ST_IGNORED;
                else
                begin
                    slot = slot_of(key);
                    if (slot >= 0)
                    begin
                        slot_ip[slot]   = ip;
                        slot_seen[slot] = now;
                        r.code = ST_UPDATED;
                        r.hit  = 1'b1;
                        r.ip   = ip;
                    end
                    else if (add)
                    begin
                        // lowest free slot takes the new neighbour
                        for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
                        begin
                            if (!slot_used[i])
                                slot = i;
                        end
                        if (slot < 0)
                            r.code = ST_FULL;
                        else
                        begin
                            slot_used[slot] = 1'b1;
                            slot_key[slot]  = key;
                            slot_ip[slot]   = ip;
                            slot_seen[slot] = now;
                            live_count      = live_count + 7'd1;
                            r.code = ST_INSERTED;
                        end
                    end
                end
            end
            KIND_REFRESH, KIND_LOOKUP:
            begin
                slot = slot_of(key);
                if (slot >= 0)
                begin
                    if (op == KIND_REFRESH)
                        slot_seen[slot] = now;
                    r.code = ST_UPDATED;
                    r.hit  = 1'b1;
                    r.ip   = slot_ip[slot];
                end
            end
            default:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = now - slot_seen[i];
                    if (slot_used[i] && age > age_limit_q)
                    begin
                        slot_used[i] = 1'b0;
                        r.removed    = r.removed + 7'd1;
                        if (live_count != 0)
                            live_count = live_count - 7'd1;
                    end
                end
                r.code = ST_UPDATED;
            end
        endcase
        r.count = live_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (n = 0; n < TABLE_ENTRIES; n++)
                slot_used[n] = 1'b0;
            live_count  = '0;
            own_addr_q  = '0;
            age_limit_q = AGE_LIMIT_RESET;
            expected_replies.delete();
            errs = 0;
            mismatch_count  <= 0;
            replies_pending <= 0;
        end
        else
        begin
            // retire first: a reply and the next request can share an edge
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: reply with no request outstanding, status %0d", $time,
                             status);
                    errs++;
                end
                else
                begin
                    oldest = expected_replies.pop_front();
                    check_field("status", 32'(oldest.code), 32'(status));
                    check_field("found", 32'(oldest.hit), 32'(found));
                    check_field("found_net_address", oldest.ip, found_net_address);
                    check_field("removed_count", 32'(oldest.removed), 32'(removed_count));
                    check_field("entry_count", 32'(oldest.count), 32'(entry_count));
                end
            end
            if (start && !busy)
            begin
                predict_table_op(kind_t'(kind), link_address, net_address, add_if_absent,
                                 now_ticks, next_reply);
                expected_replies.push_back(next_reply);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OWN_ADDRESS)
                    own_addr_q = cfg_data;
                else
                    age_limit_q = cfg_data;
            end
            mismatch_count  <= errs;
            replies_pending <= expected_replies.size();
        end
    end

endmodule

[verif/neighbour_table_with_aging_tb.sv]
`timescale 1ns / 1ps

module neighbour_table_with_aging_tb;

    import nt_pkg::*;

    localparam int POOL_SIZE   = 96;
    localparam int PHASE_OPS   = 200;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = TABLE_ENTRIES + 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] link_address;
    logic [31:0] net_address;
    logic        add_if_absent;
    logic [31:0] now_ticks;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [2:0]  status;
    logic        found;
    logic [31:0] found_net_address;
    logic [6:0]  removed_count;
    logic [6:0]  entry_count;
    int          mismatch_count;
    int          replies_pending;

    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] own_cfg;
    logic [31:0] ticks;
    int          quiet_left;
    int          stall_cycles;

    neighbour_table_with_aging dut (.*);

    neighbour_table_checker checker_i (.*);

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            quiet_left = 30;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 6);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_op(input kind_t op, input logic [31:0] key, input logic [31:0] ip,
                           input logic add, input logic [31:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        kind          <= op;
        link_address  <= key;
        net_address   <= ip;
        add_if_absent <= add;
        now_ticks     <= now;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        int gap;
        gap = pick_gap() % 8;
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [31:0] own, input logic [31:0] limit);
        start <= 1'b0;
        do @(posedge clk); while (replies_pending != 0 || busy);
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_AGE_LIMIT, limit);
        cfg_valid <= 1'b0;
        own_cfg = own;
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 84)
            return '0;
        if (r < 88)
            return RESERVED_LINK;
        if (r < 92)
            return own_cfg;
        if (r < 94)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 9)
            return '1;
        return $urandom;
    endfunction

    task automatic random_op();
        int    r;
        kind_t op;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = KIND_LEARN;
        else if (r < 63)
            op = KIND_REFRESH;
        else if (r < 85)
            op = KIND_LOOKUP;
        else
            op = KIND_SWEEP;
        r = $urandom_range(0, 99);
        if (r < 95)
            ticks = ticks + ((r < 10) ? 32'd0 : 32'($urandom_range(1, 600)));
        else
            ticks = $urandom;
        send_op(op, pick_key(), pick_ip(), $urandom_range(0, 9) < 7, ticks);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        kind          <= KIND_LEARN;
        link_address  <= '0;
        net_address   <= '0;
        add_if_absent <= 1'b0;
        now_ticks     <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_OWN_ADDRESS;
        cfg_data      <= '0;
        stall_cycles  <= 0;
        quiet_left    = 0;
        own_cfg       = '0;
        ticks         = $urandom;
        // distinct top bits keep the pool free of duplicates, zero and the reserved key
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {7'(i + 1), 25'($urandom)};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(32'hDEAD_BEEF, AGE_LIMIT_RESET);
        send_op(KIND_LOOKUP,  32'h11, 32'h0, 1'b0, 32'd0);
        send_op(KIND_REFRESH, 32'h11, 32'h0, 1'b1, 32'd5);
        send_op(KIND_SWEEP,   32'h0,  32'h0, 1'b0, 32'd0);
        send_op(KIND_LEARN,   32'h0,  32'h1, 1'b1, 32'd0);
        send_op(KIND_LEARN,   RESERVED_LINK, 32'h1, 1'b1, 32'd0);
        send_op(KIND_LEARN,   32'hDEAD_BEEF, 32'h1, 1'b1, 32'd0);
        send_op(KIND_LEARN,   32'h11, 32'h0, 1'b1, 32'd0);
        send_op(KIND_LEARN,   32'h11, 32'h5, 1'b0, 32'd0);
        send_op(KIND_LEARN,   '1, '1, 1'b1, '1);
        send_op(KIND_LEARN,   32'h1, 32'h1, 1'b1, 32'd0);
        send_op(KIND_LEARN,   '1, 32'h5, 1'b0, '1);
        send_op(KIND_LEARN,   32'h1, 32'h8000_0000, 1'b1, 32'd0);
        send_op(KIND_REFRESH, 32'h1, 32'h0, 1'b0, 32'd100);
        send_op(KIND_LOOKUP,  '1, 32'h0, 1'b0, 32'd0);
        // age wraps past zero: one tick over the limit
        send_op(KIND_SWEEP,   32'h0, 32'h0, 1'b0, 32'd10240);
        send_op(KIND_LOOKUP,  '1, 32'h0, 1'b0, 32'd0);
        // age exactly at the limit survives, one more tick does not
        send_op(KIND_SWEEP,   '1, '1, 1'b1, 32'd10340);
        send_op(KIND_SWEEP,   32'h0, 32'h0, 1'b0, 32'd10341);
        send_op(KIND_REFRESH, 32'h1, 32'h0, 1'b0, 32'd10341);
        send_op(KIND_LEARN,   32'h11, 32'h7, 1'b1, 32'd10341);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config($urandom, AGE_LIMIT_RESET);
                1: set_config('1, '1);
                2: set_config('0, '0);
                3: set_config(key_pool[$urandom_range(0, POOL_SIZE - 1)],
                              $urandom_range(200, 5000));
                default: set_config(RESERVED_LINK, $urandom);
            endcase
            if (phase == 1)
            begin
                // sweeps cannot remove anything here, so filling the table sticks
                for (int i = 0; i < 70; i++)
                begin
                    ticks = ticks + 32'($urandom_range(0, 50));
                    send_op(KIND_LEARN, key_pool[i], {$urandom} | 32'h1, 1'b1, ticks);
                end
            end
            for (int i = 0; i < PHASE_OPS; i++)
                random_op();
        end

        start <= 1'b0;
        do @(posedge clk); while (replies_pending != 0 || busy);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
